// File: rtl/core/bfha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants for the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int REQ_W       = 15;
  localparam int OFF_W       = 14;
  localparam int STATUS_W    = 2;
  localparam int SIZE_W      = 16;  // rounded request can reach 0x8000
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic [SIZE_W-1:0] ALIGN_BYTES = 16'd8;
  localparam logic [SIZE_W-1:0] ALIGN_MASK  = 16'h0007;

  localparam logic OPCODE_ALLOC = 1'b0;
  localparam logic OPCODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_DISP,
    ST_AW_RD, ST_AW_CHK, ST_SC,
    ST_AL_RD, ST_AL_W1, ST_AL_W2,
    ST_RM0, ST_RM1, ST_RM_CHK,
    ST_IN_HD, ST_IN_H1, ST_IN_NX, ST_IN_TAIL, ST_IN_CMP, ST_IN_FIX,
    ST_FS, ST_FB, ST_FR1, ST_FM0, ST_FM1, ST_FP_CHK, ST_FP0, ST_FP1,
    ST_FAIL_INV, ST_FAIL_NOFIT, ST_FAIL_FULL, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_LOAD, OP_DISP,
    OP_AW_RD, OP_AW_CHK, OP_SC,
    OP_AL_RD, OP_AL_W1, OP_AL_W2,
    OP_RM0, OP_RM1, OP_RM_CHK,
    OP_IN_HD, OP_IN_H1, OP_IN_NX, OP_IN_TAIL, OP_IN_CMP, OP_IN_FIX,
    OP_FS, OP_FB, OP_FR1, OP_FM0, OP_FM1, OP_FP_CHK, OP_FP0, OP_FP1,
    OP_FAIL_INV, OP_FAIL_NOFIT, OP_FAIL_FULL, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic off_low;
    logic t_none;
    logic fit;
    logic slot_free;
    logic idx_last;
    logic start_hit;
    logic b_busy;
    logic n_merge;
    logic p_merge;
    logic head_none;
    logic head_is_e;
    logic link_none;
    logic link_is_e;
    logic ins_lt;
    logic ins_mid;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/best_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Heap block manager: size-ordered free list, splitting on allocate,
// coalescing with neighbours on free.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: opcode; tdata: request_bytes, user_offset
//   m_*      out  m_tvalid/m_tready  tdata: status, granted_offset
//
// One word at a time. Allocate walks the free list, scans the table for a spare
// slot, then runs the unlink walk and the insert walk. Free scans the table
// slots to find the block, plus the same unlink/insert walks. The link and
// size tables each have a single read port.
// After rst the ST_INIT state writes the initial block before s_tready rises.
// A result held in the output register does not stop the next word from
// starting; it only waits if a second result is ready before it is taken.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bfha_pkg::IN_TDATA_W-1:0]   s_tdata,   // request_bytes[14:0], user_offset[28:15]
  input  logic                              s_tuser,   // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bfha_pkg::OUT_TDATA_W-1:0]  m_tdata    // status[1:0], granted_offset[15:2]
);
  import bfha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: rtl/core/bfha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/bfha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfha_ctrl
// Sequencer for the allocator: steps the datapath through list walks and
// table updates, with remove and insert shared as subroutines.
// ----------------------------------------------------------------------------
module bfha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  bfha_pkg::dp_stat_t stat,
  output bfha_pkg::dp_cmd_t  cmd
);
  import bfha_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      ret   <= ST_DONE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: if (s_tvalid) state_next = ST_DISP;
      ST_DISP: begin
        if (stat.is_alloc) state_next = ST_AW_RD;
        else if (stat.off_low) state_next = ST_FAIL_INV;
        else state_next = ST_FS;
      end
      ST_AW_RD:  state_next = stat.t_none ? ST_FAIL_NOFIT : ST_AW_CHK;
      ST_AW_CHK: state_next = stat.fit ? ST_SC : ST_AW_RD;
      ST_SC: begin
        if (stat.slot_free) begin
          state_next = ST_RM0;
          ret_next   = ST_AL_RD;
        end else if (stat.idx_last) begin
          state_next = ST_FAIL_FULL;
        end
      end
      ST_AL_RD: state_next = ST_AL_W1;
      ST_AL_W1: state_next = ST_AL_W2;
      ST_AL_W2: begin
        state_next = ST_IN_HD;
        ret_next   = ST_DONE;
      end
      ST_RM0: state_next = ST_RM1;
      ST_RM1: begin
        if (stat.head_is_e || stat.head_none) state_next = ret;
        else state_next = ST_RM_CHK;
      end
      ST_RM_CHK: if (stat.link_none || stat.link_is_e) state_next = ret;
      ST_IN_HD:  state_next = stat.head_none ? ret : ST_IN_H1;
      ST_IN_H1:  state_next = stat.ins_lt ? ret : ST_IN_NX;
      ST_IN_NX:  state_next = stat.link_none ? ST_IN_TAIL : ST_IN_CMP;
      ST_IN_TAIL: state_next = ret;
      ST_IN_CMP: state_next = stat.ins_mid ? ST_IN_FIX : ST_IN_NX;
      ST_IN_FIX: state_next = ret;
      ST_FS: begin
        if (stat.start_hit) state_next = ST_FB;
        else if (stat.idx_last) state_next = ST_FAIL_INV;
      end
      ST_FB: state_next = stat.b_busy ? ST_FR1 : ST_FAIL_INV;
      ST_FR1: begin
        if (stat.n_merge) begin
          state_next = ST_RM0;
          ret_next   = ST_FM0;
        end else begin
          state_next = ST_FP_CHK;
        end
      end
      ST_FM0: state_next = ST_FM1;
      ST_FM1: state_next = ST_FP_CHK;
      ST_FP_CHK: begin
        state_next = ST_RM0;
        ret_next   = stat.p_merge ? ST_FP0 : ST_DONE;
        if (!stat.p_merge) state_next = ST_IN_HD;
      end
      ST_FP0: state_next = ST_FP1;
      ST_FP1: begin
        state_next = ST_IN_HD;
        ret_next   = ST_DONE;
      end
      ST_FAIL_INV, ST_FAIL_NOFIT, ST_FAIL_FULL: state_next = ST_DONE;
      ST_DONE: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd.op   = OP_NOP;
    case (state)
      ST_INIT: cmd.op = OP_INIT;
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.op   = s_tvalid ? OP_LOAD : OP_NOP;
      end
      ST_DISP:       cmd.op = OP_DISP;
      ST_AW_RD:      cmd.op = OP_AW_RD;
      ST_AW_CHK:     cmd.op = OP_AW_CHK;
      ST_SC:         cmd.op = OP_SC;
      ST_AL_RD:      cmd.op = OP_AL_RD;
      ST_AL_W1:      cmd.op = OP_AL_W1;
      ST_AL_W2:      cmd.op = OP_AL_W2;
      ST_RM0:        cmd.op = OP_RM0;
      ST_RM1:        cmd.op = OP_RM1;
      ST_RM_CHK:     cmd.op = OP_RM_CHK;
      ST_IN_HD:      cmd.op = OP_IN_HD;
      ST_IN_H1:      cmd.op = OP_IN_H1;
      ST_IN_NX:      cmd.op = OP_IN_NX;
      ST_IN_TAIL:    cmd.op = OP_IN_TAIL;
      ST_IN_CMP:     cmd.op = OP_IN_CMP;
      ST_IN_FIX:     cmd.op = OP_IN_FIX;
      ST_FS:         cmd.op = OP_FS;
      ST_FB:         cmd.op = OP_FB;
      ST_FR1:        cmd.op = OP_FR1;
      ST_FM0:        cmd.op = OP_FM0;
      ST_FM1:        cmd.op = OP_FM1;
      ST_FP_CHK:     cmd.op = OP_FP_CHK;
      ST_FP0:        cmd.op = OP_FP0;
      ST_FP1:        cmd.op = OP_FP1;
      ST_FAIL_INV:   cmd.op = OP_FAIL_INV;
      ST_FAIL_NOFIT: cmd.op = OP_FAIL_NOFIT;
      ST_FAIL_FULL:  cmd.op = OP_FAIL_FULL;
      ST_DONE:       cmd.op = stat.out_free ? OP_OUT : OP_NOP;
      default:       cmd.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/core/bfha_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfha_dp
// Allocator datapath: block table RAMs, walk pointers, size arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module bfha_dp #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bfha_pkg::dp_cmd_t                    cmd,
  output bfha_pkg::dp_stat_t                   stat,
  input  logic [bfha_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bfha_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import bfha_pkg::*;

  localparam int SW = $clog2(HEAP_BYTES + 1);          // start / byte count width
  localparam int CW = ((SW > SIZE_W) ? SW : SIZE_W) + 1; // arithmetic width
  localparam int LW = $clog2(MAX_BLOCKS + 1);          // link incl. "none"
  localparam int IW = $clog2(MAX_BLOCKS);              // table index
  localparam logic [LW-1:0] NONE  = LW'(MAX_BLOCKS);
  localparam logic [CW-1:0] HDR   = CW'(HEADER_BYTES);
  localparam logic [IW-1:0] LAST  = IW'(MAX_BLOCKS - 1);

  function automatic logic [IW-1:0] ix(input logic [LW-1:0] v);
    return v[IW-1:0];
  endfunction

  function automatic logic [LW-1:0] lk(input logic [IW-1:0] v);
    return LW'(v);
  endfunction

  // working registers
  logic                 opcode;
  logic [SIZE_W-1:0]    size;
  logic [OFF_W-1:0]     off;
  logic [LW-1:0]        head, t, nb, e, w, nn, pp, bnext, nx, elink;
  logic [IW-1:0]        idx, b;
  logic [SW-1:0]        tbytes, wbytes, bbytes, ins_sz;
  logic [STATUS_W-1:0]  res_status;
  logic [OFF_W-1:0]     res_granted;
  logic [MAX_BLOCKS-1:0] in_use, busy;

  // RAM ports
  logic          st_we, st_re, by_we, by_re, ln_we, ln_re, nx_we, nx_re, pv_we, pv_re;
  logic [IW-1:0] st_wa, st_ra, by_wa, by_ra, ln_wa, ln_ra, nx_wa, nx_ra, pv_wa, pv_ra;
  logic [SW-1:0] st_wd, st_rd, by_wd, by_rd;
  logic [LW-1:0] ln_wd, ln_rd, nx_wd, nx_rd, pv_wd, pv_rd;

  logic [CW-1:0] new_start, split_bytes, merge_n_bytes, merge_p_bytes, granted_sum;
  logic [CW-1:0] target;
  logic [SIZE_W-1:0] size_in;

  assign new_start     = CW'(st_rd) + HDR + CW'(size);
  assign granted_sum   = CW'(st_rd) + HDR;
  assign split_bytes   = CW'(tbytes) - CW'(size) - HDR;
  assign merge_n_bytes = CW'(bbytes) + CW'(by_rd) + HDR;
  assign merge_p_bytes = CW'(by_rd) + CW'(bbytes) + HDR;
  assign target        = CW'(off) - HDR;
  assign size_in       = (SIZE_W'(s_tdata[REQ_W-1:0]) + ALIGN_MASK) & ~ALIGN_MASK;

  always_comb begin
    stat.is_alloc  = (opcode == OPCODE_ALLOC);
    stat.off_low   = CW'(off) < HDR;
    stat.t_none    = !(t < NONE);
    stat.fit       = CW'(by_rd) > CW'(size) + HDR;
    stat.slot_free = !in_use[idx];
    stat.idx_last  = (idx == LAST);
    stat.start_hit = in_use[idx] && (CW'(st_rd) == target);
    stat.b_busy    = busy[b];
    stat.n_merge   = (nx_rd < NONE) && !busy[ix(nx_rd)];
    stat.p_merge   = (pp < NONE) && !busy[ix(pp)];
    stat.head_none = !(head < NONE);
    stat.head_is_e = (head == e);
    stat.link_none = !(ln_rd < NONE);
    stat.link_is_e = (ln_rd == e);
    stat.ins_lt    = ins_sz < by_rd;
    stat.ins_mid   = (ins_sz >= wbytes) && (ins_sz <= by_rd);
    stat.out_free  = !m_tvalid || m_tready;
  end

  // RAM port steering
  always_comb begin
    st_we = 1'b0; st_re = 1'b0; st_wa = '0; st_ra = '0; st_wd = '0;
    by_we = 1'b0; by_re = 1'b0; by_wa = '0; by_ra = '0; by_wd = '0;
    ln_we = 1'b0; ln_re = 1'b0; ln_wa = '0; ln_ra = '0; ln_wd = '0;
    nx_we = 1'b0; nx_re = 1'b0; nx_wa = '0; nx_ra = '0; nx_wd = '0;
    pv_we = 1'b0; pv_re = 1'b0; pv_wa = '0; pv_ra = '0; pv_wd = '0;
    case (cmd.op)
      OP_INIT: begin
        st_we = 1'b1; st_wd = '0;
        by_we = 1'b1; by_wd = SW'(HEAP_BYTES - HEADER_BYTES);
        ln_we = 1'b1; ln_wd = NONE;
        nx_we = 1'b1; nx_wd = NONE;
        pv_we = 1'b1; pv_wd = NONE;
      end
      OP_DISP: begin
        st_re = 1'b1;
      end
      OP_AW_RD: begin
        by_re = 1'b1; by_ra = ix(t);
        ln_re = 1'b1; ln_ra = ix(t);
      end
      OP_AL_RD: begin
        st_re = 1'b1; st_ra = ix(t);
        nx_re = 1'b1; nx_ra = ix(t);
      end
      OP_AL_W1: begin
        st_we = 1'b1; st_wa = ix(nb); st_wd = new_start[SW-1:0];
        by_we = 1'b1; by_wa = ix(nb); by_wd = split_bytes[SW-1:0];
        pv_we = 1'b1; pv_wa = ix(nb); pv_wd = t;
        nx_we = 1'b1; nx_wa = ix(nb); nx_wd = nx_rd;
        ln_we = 1'b1; ln_wa = ix(nb); ln_wd = NONE;
      end
      OP_AL_W2: begin
        by_we = 1'b1; by_wa = ix(t); by_wd = SW'(size);
        nx_we = 1'b1; nx_wa = ix(t); nx_wd = nb;
        pv_we = (nx < NONE); pv_wa = ix(nx); pv_wd = nb;
      end
      OP_RM0: begin
        ln_re = 1'b1; ln_ra = ix(e);
      end
      OP_RM1: begin
        ln_re = 1'b1; ln_ra = ix(head);
      end
      OP_RM_CHK: begin
        ln_re = 1'b1; ln_ra = ix(ln_rd);
        ln_we = (ln_rd < NONE) && (ln_rd == e); ln_wa = ix(w); ln_wd = elink;
      end
      OP_IN_HD: begin
        by_re = 1'b1; by_ra = ix(head);
        ln_re = 1'b1; ln_ra = ix(head);
        ln_we = !(head < NONE); ln_wa = ix(e); ln_wd = NONE;
      end
      OP_IN_H1: begin
        ln_we = ins_sz < by_rd; ln_wa = ix(e); ln_wd = w;
      end
      OP_IN_NX: begin
        by_re = 1'b1; by_ra = ix(ln_rd);
        ln_re = (ln_rd < NONE); ln_ra = ix(ln_rd);
        ln_we = !(ln_rd < NONE); ln_wa = ix(w); ln_wd = e;
      end
      OP_IN_TAIL: begin
        ln_we = 1'b1; ln_wa = ix(e); ln_wd = NONE;
      end
      OP_IN_CMP: begin
        ln_we = (ins_sz >= wbytes) && (ins_sz <= by_rd); ln_wa = ix(e); ln_wd = nn;
      end
      OP_IN_FIX: begin
        ln_we = 1'b1; ln_wa = ix(w); ln_wd = e;
      end
      OP_FS: begin
        st_re = 1'b1; st_ra = IW'(idx + 1'b1);
      end
      OP_FB: begin
        nx_re = 1'b1; nx_ra = b;
        pv_re = 1'b1; pv_ra = b;
        by_re = 1'b1; by_ra = b;
      end
      OP_FM0: begin
        by_re = 1'b1; by_ra = ix(e);
        nx_re = 1'b1; nx_ra = ix(e);
      end
      OP_FM1: begin
        by_we = 1'b1; by_wa = b; by_wd = merge_n_bytes[SW-1:0];
        nx_we = 1'b1; nx_wa = b; nx_wd = nx_rd;
        pv_we = (nx_rd < NONE); pv_wa = ix(nx_rd); pv_wd = lk(b);
      end
      OP_FP0: begin
        by_re = 1'b1; by_ra = ix(pp);
      end
      OP_FP1: begin
        by_we = 1'b1; by_wa = ix(pp); by_wd = merge_p_bytes[SW-1:0];
        nx_we = 1'b1; nx_wa = ix(pp); nx_wd = bnext;
        pv_we = (bnext < NONE); pv_wa = ix(bnext); pv_wd = pp;
      end
      default: begin
      end
    endcase
  end

  // control state: occupancy, allocation flags, list head, output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= MAX_BLOCKS'(1);
      busy     <= '0;
      head     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_AL_W1: begin
          in_use[ix(nb)] <= 1'b1;
          busy[ix(nb)]   <= 1'b0;
          busy[ix(t)]    <= 1'b1;
        end
        OP_RM1: if (head == e) head <= ln_rd;
        OP_IN_HD: if (!(head < NONE)) head <= e;
        OP_IN_H1: if (ins_sz < by_rd) head <= e;
        OP_FB: if (busy[b]) busy[b] <= 1'b0;
        OP_FM1: in_use[ix(e)] <= 1'b0;
        OP_FP1: in_use[b] <= 1'b0;
        default: begin
        end
      endcase
      if (cmd.op == OP_OUT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        opcode      <= s_tuser;
        size        <= size_in;
        off         <= s_tdata[REQ_W +: OFF_W];
        res_status  <= STATUS_OK;
        res_granted <= '0;
      end
      OP_DISP: begin
        t   <= head;
        idx <= '0;
      end
      OP_AW_CHK: begin
        tbytes <= by_rd;
        if (!(CW'(by_rd) > CW'(size) + HDR)) t <= ln_rd;
      end
      OP_SC: begin
        nb <= lk(idx);
        e  <= t;
        if (in_use[idx]) idx <= IW'(idx + 1'b1);
      end
      OP_AL_W1: begin
        res_granted <= granted_sum[OFF_W-1:0];
        nx          <= nx_rd;
        e           <= nb;
        ins_sz      <= split_bytes[SW-1:0];
      end
      OP_RM1: begin
        elink <= ln_rd;
        w     <= head;
      end
      OP_RM_CHK: w <= ln_rd;
      OP_IN_HD: w <= head;
      OP_IN_H1: wbytes <= by_rd;
      OP_IN_NX: nn <= ln_rd;
      OP_IN_CMP: begin
        // w stays on the predecessor when the slot is found
        if (!stat.ins_mid) begin
          w      <= nn;
          wbytes <= by_rd;
        end
      end
      OP_FS: begin
        b <= idx;
        if (!(in_use[idx] && (CW'(st_rd) == target))) idx <= IW'(idx + 1'b1);
      end
      OP_FR1: begin
        bnext  <= nx_rd;
        pp     <= pv_rd;
        bbytes <= by_rd;
        e      <= nx_rd;
      end
      OP_FM1: begin
        bbytes <= merge_n_bytes[SW-1:0];
        bnext  <= nx_rd;
      end
      OP_FP_CHK: begin
        e      <= ((pp < NONE) && !busy[ix(pp)]) ? pp : lk(b);
        ins_sz <= bbytes;
      end
      OP_FP1: begin
        e      <= pp;
        ins_sz <= merge_p_bytes[SW-1:0];
      end
      OP_FAIL_INV: begin
        res_status  <= STATUS_INVALID;
        res_granted <= '0;
      end
      OP_FAIL_NOFIT: begin
        res_status  <= STATUS_NO_FIT;
        res_granted <= '0;
      end
      OP_FAIL_FULL: begin
        res_status  <= STATUS_FULL;
        res_granted <= '0;
      end
      OP_OUT: m_tdata <= {res_granted, res_status};
      default: begin
      end
    endcase
  end

  bfha_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_start_ram (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
    .re(st_re), .raddr(st_ra), .rdata(st_rd)
  );

  bfha_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_bytes_ram (
    .clk(clk), .we(by_we), .waddr(by_wa), .wdata(by_wd),
    .re(by_re), .raddr(by_ra), .rdata(by_rd)
  );

  bfha_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_link_ram (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd),
    .re(ln_re), .raddr(ln_ra), .rdata(ln_rd)
  );

  bfha_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
  );

  bfha_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .re(pv_re), .raddr(pv_ra), .rdata(pv_rd)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for best_fit_heap_allocator. A behavioural copy of the
// block table, address chain and size-ordered free chain predicts each result
// word. A short directed table is followed by a random allocate/free mix that
// includes a burst to fill the block table. Both sides are throttled at
// random, with one calm stretch.
// ----------------------------------------------------------------------------
module testbench;
  import bfha_pkg::*;

  localparam int HEAP   = 16384;
  localparam int HDR    = 24;
  localparam int SLOTS  = 64;
  localparam int NONE   = SLOTS;
  localparam int LIMIT  = 3000000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    granted;
  } grant_t;

  typedef struct {
    logic        op;
    int unsigned req;
    int unsigned off;
    bit          typed;
    grant_t      want;
  } row_t;

  grant_t      pending_grants[$];
  int unsigned live_offsets[$];
  int          fails = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          n_status[4] = '{0, 0, 0, 0};

  // shadow of the block table
  int unsigned blk_start[SLOTS], blk_len[SLOTS];
  bit          blk_busy[SLOTS], blk_used[SLOTS];
  int unsigned addr_nxt[SLOTS], addr_prv[SLOTS], free_nxt[SLOTS];
  int unsigned free_head;

  best_fit_heap_allocator #(
    .HEAP_BYTES(HEAP), .HEADER_BYTES(HDR), .MAX_BLOCKS(SLOTS)
  ) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void heap_clear();
    for (int i = 0; i < SLOTS; i++) begin
      blk_start[i] = 0; blk_len[i] = 0; blk_busy[i] = 0; blk_used[i] = 0;
      addr_nxt[i] = NONE; addr_prv[i] = NONE; free_nxt[i] = NONE;
    end
    blk_len[0] = HEAP - HDR;
    blk_used[0] = 1;
    free_head = 0;
  endfunction

  function automatic void free_unlink(int unsigned e);
    int unsigned p;
    int          steps;
    p = free_head;
    steps = 0;
    if (e >= NONE || p >= NONE) return;
    if (p == e) begin
      free_head = free_nxt[e];
      return;
    end
    while (p < NONE && free_nxt[p] < NONE && steps < SLOTS) begin
      if (free_nxt[p] == e) begin
        free_nxt[p] = free_nxt[e];
        return;
      end
      p = free_nxt[p];
      steps++;
    end
  endfunction

  // head if empty or smaller, else after first element bracketing its size, else tail
  function automatic void free_link(int unsigned e);
    int unsigned p, n;
    int          steps;
    p = free_head;
    steps = 0;
    if (p >= NONE) begin
      free_head = e;
      free_nxt[e] = NONE;
      return;
    end
    if (blk_len[e] < blk_len[p]) begin
      free_nxt[e] = p;
      free_head = e;
      return;
    end
    while (free_nxt[p] < NONE && steps < SLOTS) begin
      n = free_nxt[p];
      if (blk_len[e] >= blk_len[p] && blk_len[e] <= blk_len[n]) begin
        free_nxt[e] = n;
        free_nxt[p] = e;
        return;
      end
      p = n;
      steps++;
    end
    free_nxt[p] = e;
    free_nxt[e] = NONE;
  endfunction

  function automatic void retire(int unsigned e);
    blk_used[e] = 0; blk_start[e] = 0; blk_len[e] = 0;
    addr_nxt[e] = NONE; addr_prv[e] = NONE; free_nxt[e] = NONE;
  endfunction

  function automatic grant_t heap_allocate(int unsigned want);
    grant_t      r;
    int unsigned sz, t, nb, nx;
    int          steps;
    r.status = STATUS_OK;
    r.granted = '0;
    sz = (want + 7) & ~32'd7;
    t = free_head;
    steps = 0;
    while (t < NONE && steps < SLOTS) begin
      if (blk_len[t] > sz + HDR) break;
      t = free_nxt[t];
      steps++;
    end
    if (t >= NONE || steps >= SLOTS) begin
      r.status = STATUS_NO_FIT;
      return r;
    end
    nb = NONE;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (!blk_used[i]) nb = i;
    if (nb >= NONE) begin
      r.status = STATUS_FULL;
      return r;
    end
    free_unlink(t);
    blk_used[nb] = 1;
    blk_busy[nb] = 0;
    blk_start[nb] = blk_start[t] + HDR + sz;
    blk_len[nb] = blk_len[t] - sz - HDR;
    blk_len[t] = sz;
    blk_busy[t] = 1;
    nx = addr_nxt[t];
    addr_prv[nb] = t;
    addr_nxt[nb] = nx;
    if (nx < NONE) addr_prv[nx] = nb;
    addr_nxt[t] = nb;
    free_nxt[nb] = NONE;
    free_link(nb);
    r.granted = OFF_W'(blk_start[t] + HDR);
    return r;
  endfunction

  function automatic grant_t heap_release(int unsigned off);
    grant_t      r;
    int unsigned b, keep, n, p;
    r.status = STATUS_INVALID;
    r.granted = '0;
    if (off < HDR) return r;
    b = NONE;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (blk_used[i] && blk_start[i] == off - HDR) b = i;
    if (b >= NONE || !blk_busy[b]) return r;
    r.status = STATUS_OK;
    blk_busy[b] = 0;
    keep = b;
    n = addr_nxt[b];
    if (n < NONE && !blk_busy[n]) begin
      free_unlink(n);
      blk_len[b] += blk_len[n] + HDR;
      addr_nxt[b] = addr_nxt[n];
      if (addr_nxt[n] < NONE) addr_prv[addr_nxt[n]] = b;
      retire(n);
    end
    p = addr_prv[b];
    if (p < NONE && !blk_busy[p]) begin
      free_unlink(p);
      blk_len[p] += blk_len[b] + HDR;
      if (addr_nxt[b] < NONE) addr_prv[addr_nxt[b]] = p;
      addr_nxt[p] = addr_nxt[b];
      retire(b);
      keep = p;
    end
    free_nxt[keep] = NONE;
    free_link(keep);
    return r;
  endfunction

  // returns the prediction and keeps the list of live grants in step
  function automatic grant_t heap_step(logic op, int unsigned req, int unsigned off);
    grant_t r;
    if (op == OPCODE_ALLOC) begin
      r = heap_allocate(req);
      if (r.status == STATUS_OK) live_offsets.push_back(r.granted);
    end else begin
      r = heap_release(off);
      if (r.status == STATUS_OK)
        foreach (live_offsets[i])
          if (live_offsets[i] == off) begin
            live_offsets.delete(i);
            break;
          end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, exp);
    fails++;
  endtask

  task automatic push_word(logic op, int unsigned req, int unsigned off, bit typed = 0,
                           grant_t want = '{STATUS_OK, '0});
    grant_t pred;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b0, off[OFF_W-1:0], req[REQ_W-1:0]};
    do @(posedge clk); while (!s_tready);
    pred = heap_step(op, req, off);
    pending_grants.push_back(typed ? want : pred);
    if (!calm && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        grant_t e;
        e = pending_grants.pop_front();
        if (m_tdata[1:0] != e.status) report_mismatch("status", m_tdata[1:0], e.status);
        if (m_tdata[15:2] != e.granted)
          report_mismatch("granted_offset", m_tdata[15:2], e.granted);
        n_status[m_tdata[1:0]]++;
      end
    end
    m_tready <= calm || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d words outstanding", pending_grants.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  row_t rows[$];

  function automatic row_t mk(logic op, int unsigned req, int unsigned off, bit typed = 0,
                              logic [STATUS_W-1:0] st = STATUS_OK, int unsigned g = 0);
    row_t r;
    r.op = op; r.req = req; r.off = off; r.typed = typed;
    r.want.status = st; r.want.granted = OFF_W'(g);
    return r;
  endfunction

  initial begin
    int unsigned req, off, pick;
    heap_clear();
    // directed: extremes, invalid and no-fit failure codes, merge both ways, exact-fit edge
    rows.push_back(mk(OPCODE_ALLOC, 0,     0,     1, STATUS_OK, HDR));
    rows.push_back(mk(OPCODE_ALLOC, 16384, 0,     1, STATUS_NO_FIT));
    rows.push_back(mk(OPCODE_FREE,  0,     0,     1, STATUS_INVALID));
    rows.push_back(mk(OPCODE_FREE,  0,     23,    1, STATUS_INVALID));
    rows.push_back(mk(OPCODE_FREE,  32767, 16383, 1, STATUS_INVALID));
    rows.push_back(mk(OPCODE_ALLOC, 1,     0));
    rows.push_back(mk(OPCODE_ALLOC, 8,     0));
    rows.push_back(mk(OPCODE_ALLOC, 9,     16383));
    rows.push_back(mk(OPCODE_ALLOC, 4000,  0));
    rows.push_back(mk(OPCODE_ALLOC, 32767, 0,     1, STATUS_NO_FIT));
    rows.push_back(mk(OPCODE_FREE,  5,     48));
    rows.push_back(mk(OPCODE_FREE,  0,     48,    1, STATUS_INVALID));
    rows.push_back(mk(OPCODE_FREE,  0,     80));
    rows.push_back(mk(OPCODE_FREE,  0,     24));
    rows.push_back(mk(OPCODE_ALLOC, 12000, 0));
    rows.push_back(mk(OPCODE_ALLOC, 16,    0));
    rows.push_back(mk(OPCODE_FREE,  0,     112));
    rows.push_back(mk(OPCODE_ALLOC, 0,     0));
    rows.push_back(mk(OPCODE_FREE,  0,     4));
    rows.push_back(mk(OPCODE_ALLOC, 200,   10922));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) push_word(rows[i].op, rows[i].req, rows[i].off, rows[i].typed,
                                rows[i].want);
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);

    for (int k = 0; k < 700; k++) begin
      calm = (k >= 250 && k < 350);
      if (k >= 400 && k < 480) begin
        // burst of tiny grants to run the block table out of slots
        push_word(OPCODE_ALLOC, $urandom_range(0, 16), $urandom_range(0, 16383));
      end else if (k >= 480 && k < 560 && live_offsets.size() != 0) begin
        pick = $urandom_range(live_offsets.size() - 1);
        push_word(OPCODE_FREE, $urandom_range(0, 32767), live_offsets[pick]);
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          pick = $urandom_range(99);
          req = pick < 80 ? $urandom_range(0, 300)
              : pick < 95 ? $urandom_range(0, 2000) : $urandom_range(0, 16384);
          push_word(OPCODE_ALLOC, req, $urandom_range(0, 16383));
        end else if (pick < 90 && live_offsets.size() != 0) begin
          pick = $urandom_range(live_offsets.size() - 1);
          push_word(OPCODE_FREE, $urandom_range(0, 32767), live_offsets[pick]);
        end else begin
          off = $urandom_range(0, 16383);
          push_word(OPCODE_FREE, $urandom_range(0, 32767), off);
        end
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered: %0d ok, %0d invalid free, %0d no fit, %0d table full words",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bfha_pkg.sv
rtl/core/bfha_ram.sv
rtl/core/bfha_ctrl.sv
rtl/core/bfha_dp.sv
rtl/core/best_fit_heap_allocator.sv
verif/testbench.sv
